>>> rtl/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

  localparam int unsigned CacheEntries = 32;
  localparam int unsigned PendEntries  = 8;
  localparam int unsigned CacheIdxW    = $clog2(CacheEntries);
  localparam int unsigned PendIdxW     = $clog2(PendEntries);

  typedef enum logic [1:0] {
    ModeLookup = 2'd0,
    ModeInsert = 2'd1,
    ModeAppend = 2'd2,
    ModeTick   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KindLookup  = 3'd0,
    KindSend    = 3'd1,
    KindRelease = 3'd2,
    KindUnreach = 3'd3,
    KindDone    = 3'd4,
    KindFull    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CfgTimeout = 2'd0,
    CfgRetries = 2'd1,
    CfgResend  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [3:0]  iface_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [31:0] out_ip;
    logic [47:0] out_mac;
    logic [3:0]  out_iface;
    logic [7:0]  packet_count;
    logic        last;
  } rsp_t;

  // Cache entry word: ip, mac, time stamp.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] added;
  } cache_ent_t;

  // Pending entry word.
  typedef struct packed {
    logic [31:0] ip;
    logic [3:0]  iface;
    logic [15:0] sent;
    logic [7:0]  retries;
    logic [7:0]  packets;
  } pend_ent_t;

  typedef enum logic [3:0] {
    StIdle,
    StCacheRd,
    StCacheChk,
    StCacheWr,
    StPendRd,
    StPendChk,
    StPendAct,
    StAppendWr,
    StOut
  } state_e;

endpackage
`default_nettype wire

>>> rtl/arpc_ram.sv
`default_nettype none
module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/arp_cache_with_request_tracking_unit.sv
`default_nettype none
// ARP cache with pending-request tracking.
// Requests enter on req_valid_i/req_stall_o with one packed req_t payload:
// a lookup, an insert, a packet append or a one-second tick. Results leave on
// rsp_valid_o/rsp_stall_i as rsp_t, the final one of each request carrying
// last. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must do so only while the unit is idle, which it does not enforce.
// One request is worked on at a time. The cache lives in a 32-entry memory
// and the pending table in an 8-entry memory, both with a registered read.
// Each request but an append sweeps the cache entry by entry (read, then
// check), an insert then writes the chosen slot, and every request but a
// lookup then sweeps the pending table entry by entry (read, check, advance).
// Every result passes through the StOut state to the output register. The
// unit returns to idle when the last result is registered and then accepts
// the next request.
// Valid bits are flip-flops cleared at reset, so the unit is ready as soon
// as reset is released. While the receiver stalls, the next result waits
// in a staging register and the sweep does not advance.
module arp_cache_with_request_tracking_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output      logic                req_stall_o,
  input  wire arpc_pkg::req_t      req_i,
  output      logic                rsp_valid_o,
  input  wire logic                rsp_stall_i,
  output      arpc_pkg::rsp_t      rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_data_i
);

  localparam int unsigned CW = arpc_pkg::CacheIdxW;
  localparam int unsigned PW = arpc_pkg::PendIdxW;

  arpc_pkg::state_e state_q, state_d, ret_q, ret_d;
  arpc_pkg::req_t   req_q, req_d;
  logic [15:0] timeout_q, timeout_d;
  logic [7:0]  retries_q, retries_d, resend_q, resend_d;
  logic [15:0] now_q, now_d;
  logic [arpc_pkg::CacheEntries-1:0] cvalid_q, cvalid_d;
  logic [arpc_pkg::PendEntries-1:0]  pvalid_q, pvalid_d;
  logic [CW:0] ci_q, ci_d;
  logic [PW:0] pi_q, pi_d;
  // Cache sweep results.
  logic        match_q, match_d, free_q, free_d, hit_q, hit_d;
  logic [CW-1:0] slot_q, slot_d;
  logic [15:0] best_q, best_d;
  logic [47:0] hmac_q, hmac_d;
  // Pending sweep results.
  logic        pfound_q, pfound_d, pfree_q, pfree_d;
  logic [PW-1:0] pslot_q, pslot_d, fslot_q, fslot_d;
  arpc_pkg::pend_ent_t fent_q, fent_d;
  logic        rsp_valid_q, rsp_valid_d;
  arpc_pkg::rsp_t rsp_q, rsp_d;
  // Next result, waiting for the output register.
  arpc_pkg::rsp_t nxt_q, nxt_d;

  logic c_we, p_we;
  logic [CW-1:0] c_waddr, c_raddr;
  logic [PW-1:0] p_waddr, p_raddr;
  arpc_pkg::cache_ent_t c_wdata, c_rdata;
  arpc_pkg::pend_ent_t  p_wdata, p_rdata;

  arpc_ram #(.Width($bits(arpc_pkg::cache_ent_t)), .Depth(arpc_pkg::CacheEntries))
  u_cache_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  arpc_ram #(.Width($bits(arpc_pkg::pend_ent_t)), .Depth(arpc_pkg::PendEntries))
  u_pend_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign req_stall_o = (state_q != arpc_pkg::StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpc_pkg::StIdle;
      ret_q       <= arpc_pkg::StIdle;
      timeout_q   <= 16'd15;
      retries_q   <= 8'd5;
      resend_q    <= 8'd1;
      now_q       <= '0;
      cvalid_q    <= '0;
      pvalid_q    <= '0;
      ci_q        <= '0;
      pi_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      timeout_q   <= timeout_d;
      retries_q   <= retries_d;
      resend_q    <= resend_d;
      now_q       <= now_d;
      cvalid_q    <= cvalid_d;
      pvalid_q    <= pvalid_d;
      ci_q        <= ci_d;
      pi_q        <= pi_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    match_q  <= match_d;
    free_q   <= free_d;
    hit_q    <= hit_d;
    slot_q   <= slot_d;
    best_q   <= best_d;
    hmac_q   <= hmac_d;
    pfound_q <= pfound_d;
    pfree_q  <= pfree_d;
    pslot_q  <= pslot_d;
    fslot_q  <= fslot_d;
    fent_q   <= fent_d;
    rsp_q    <= rsp_d;
    nxt_q    <= nxt_d;
  end

  always_comb begin
    logic [CW-1:0] ci;
    logic [PW-1:0] pi;
    logic [15:0]   age;
    logic          out_free;
    state_d     = state_q;
    ret_d       = ret_q;
    timeout_d   = timeout_q;
    retries_d   = retries_q;
    resend_d    = resend_q;
    now_d       = now_q;
    cvalid_d    = cvalid_q;
    pvalid_d    = pvalid_q;
    ci_d        = ci_q;
    pi_d        = pi_q;
    req_d       = req_q;
    match_d     = match_q;
    free_d      = free_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    best_d      = best_q;
    hmac_d      = hmac_q;
    pfound_d    = pfound_q;
    pfree_d     = pfree_q;
    pslot_d     = pslot_q;
    fslot_d     = fslot_q;
    fent_d      = fent_q;
    rsp_d       = rsp_q;
    nxt_d       = nxt_q;
    ci          = ci_q[CW-1:0];
    pi          = pi_q[PW-1:0];
    age         = '0;
    out_free    = !rsp_valid_q || !rsp_stall_i;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    c_we        = 1'b0;
    c_waddr     = slot_q;
    c_wdata     = '{ip: req_q.ip_addr, mac: req_q.mac_addr, added: now_q};
    c_raddr     = ci;
    p_we        = 1'b0;
    p_waddr     = pi;
    p_wdata     = p_rdata;
    p_raddr     = pi;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arpc_pkg::CfgTimeout: timeout_d = cfg_data_i;
        arpc_pkg::CfgRetries: retries_d = cfg_data_i[7:0];
        arpc_pkg::CfgResend:  resend_d  = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      arpc_pkg::StIdle: begin
        if (req_valid_i) begin
          req_d    = req_i;
          ci_d     = '0;
          pi_d     = '0;
          match_d  = 1'b0;
          free_d   = 1'b0;
          hit_d    = 1'b0;
          slot_d   = '0;
          best_d   = '0;
          hmac_d   = '0;
          pfound_d = 1'b0;
          pfree_d  = 1'b0;
          pslot_d  = '0;
          fslot_d  = '0;
          fent_d   = '0;
          if (req_i.mode == arpc_pkg::ModeTick) begin
            now_d = now_q + 16'd1;
          end
          state_d = (req_i.mode == arpc_pkg::ModeAppend) ? arpc_pkg::StPendRd
                                                         : arpc_pkg::StCacheRd;
        end
      end
      arpc_pkg::StCacheRd: begin
        state_d = arpc_pkg::StCacheChk;
      end
      arpc_pkg::StCacheChk: begin
        age = now_q - c_rdata.added;
        state_d = arpc_pkg::StCacheRd;
        unique case (req_q.mode)
          arpc_pkg::ModeLookup: begin
            if (cvalid_q[ci] && c_rdata.ip == req_q.ip_addr && !hit_q) begin
              hit_d  = 1'b1;
              hmac_d = c_rdata.mac;
            end
          end
          arpc_pkg::ModeInsert: begin
            if (!match_q) begin
              if (cvalid_q[ci] && c_rdata.ip == req_q.ip_addr) begin
                match_d = 1'b1;
                slot_d  = ci;
              end else if (!free_q) begin
                if (!cvalid_q[ci]) begin
                  free_d = 1'b1;
                  slot_d = ci;
                end else if (ci == '0 || age > best_q) begin
                  slot_d = ci;
                  best_d = age;
                end
              end
            end
          end
          arpc_pkg::ModeTick: begin
            if (cvalid_q[ci] && age > timeout_q) begin
              cvalid_d[ci] = 1'b0;
            end
          end
          default: ;
        endcase
        if (ci_q == (CW+1)'(arpc_pkg::CacheEntries - 1)) begin
          ci_d = '0;
          if (req_q.mode == arpc_pkg::ModeLookup) begin
            state_d = arpc_pkg::StOut;
            ret_d   = arpc_pkg::StIdle;
            nxt_d   = '{kind: arpc_pkg::KindLookup, hit: hit_d, out_ip: req_q.ip_addr,
                        out_mac: hit_d ? hmac_d : 48'd0, out_iface: 4'd0,
                        packet_count: 8'd0, last: 1'b1};
          end else if (req_q.mode == arpc_pkg::ModeInsert) begin
            state_d = arpc_pkg::StCacheWr;
          end else begin
            state_d = arpc_pkg::StPendRd;
          end
        end else begin
          ci_d = ci_q + 1'b1;
        end
      end
      arpc_pkg::StCacheWr: begin
        c_we = 1'b1;
        cvalid_d[slot_q] = 1'b1;
        state_d = arpc_pkg::StPendRd;
      end
      arpc_pkg::StPendRd: begin
        state_d = arpc_pkg::StPendChk;
      end
      arpc_pkg::StPendChk: begin
        // Default: step to next entry unless an action needs a result.
        state_d = arpc_pkg::StPendAct;
        ret_d   = arpc_pkg::StPendRd;
        age     = now_q - p_rdata.sent;
        unique case (req_q.mode)
          arpc_pkg::ModeInsert: begin
            if (pvalid_q[pi] && p_rdata.ip == req_q.ip_addr) begin
              pvalid_d[pi] = 1'b0;
              nxt_d = '{kind: arpc_pkg::KindRelease, hit: 1'b0, out_ip: req_q.ip_addr,
                        out_mac: req_q.mac_addr, out_iface: p_rdata.iface,
                        packet_count: p_rdata.packets, last: 1'b0};
              state_d = arpc_pkg::StOut;
              ret_d   = arpc_pkg::StPendAct;
            end
          end
          arpc_pkg::ModeAppend: begin
            if (pvalid_q[pi]) begin
              if (!pfound_q && p_rdata.ip == req_q.ip_addr &&
                  p_rdata.iface == req_q.iface_id) begin
                pfound_d = 1'b1;
                pslot_d  = pi;
                fent_d   = p_rdata;
              end
            end else if (!pfree_q) begin
              pfree_d = 1'b1;
              fslot_d = pi;
            end
          end
          arpc_pkg::ModeTick: begin
            if (pvalid_q[pi]) begin
              if (p_rdata.retries > retries_q) begin
                pvalid_d[pi] = 1'b0;
                nxt_d = '{kind: arpc_pkg::KindUnreach, hit: 1'b0, out_ip: p_rdata.ip,
                          out_mac: 48'd0, out_iface: p_rdata.iface,
                          packet_count: p_rdata.packets, last: 1'b0};
                state_d = arpc_pkg::StOut;
                ret_d   = arpc_pkg::StPendAct;
              end else if (age > 16'(resend_q)) begin
                p_we = 1'b1;
                p_wdata.sent = now_q;
                if (p_rdata.retries != 8'hFF) begin
                  p_wdata.retries = p_rdata.retries + 8'd1;
                end
                nxt_d = '{kind: arpc_pkg::KindSend, hit: 1'b0, out_ip: p_rdata.ip,
                          out_mac: 48'd0, out_iface: p_rdata.iface,
                          packet_count: 8'd0, last: 1'b0};
                state_d = arpc_pkg::StOut;
                ret_d   = arpc_pkg::StPendAct;
              end
            end
          end
          default: ;
        endcase
      end
      arpc_pkg::StPendAct: begin
        // Advance the pending sweep, or finish the request.
        if (pi_q == (PW+1)'(arpc_pkg::PendEntries - 1)) begin
          pi_d = '0;
          if (req_q.mode == arpc_pkg::ModeAppend) begin
            state_d = arpc_pkg::StAppendWr;
          end else begin
            nxt_d = '{kind: arpc_pkg::KindDone, hit: 1'b0, out_ip: 32'd0, out_mac: 48'd0,
                      out_iface: 4'd0, packet_count: 8'd0, last: 1'b1};
            state_d = arpc_pkg::StOut;
            ret_d   = arpc_pkg::StIdle;
          end
        end else begin
          pi_d    = pi_q + 1'b1;
          state_d = arpc_pkg::StPendRd;
        end
      end
      arpc_pkg::StAppendWr: begin
        state_d = arpc_pkg::StOut;
        if (pfound_q) begin
          // Only the packet count changes; the rest of the entry is kept.
          if (fent_q.packets != 8'hFF) begin
            p_we            = 1'b1;
            p_waddr         = pslot_q;
            p_wdata         = fent_q;
            p_wdata.packets = fent_q.packets + 8'd1;
          end
          nxt_d = '{kind: arpc_pkg::KindDone, hit: 1'b0, out_ip: 32'd0, out_mac: 48'd0,
                    out_iface: 4'd0, packet_count: 8'd0, last: 1'b1};
          ret_d = arpc_pkg::StIdle;
        end else if (pfree_q) begin
          p_we    = 1'b1;
          p_waddr = fslot_q;
          p_wdata = '{ip: req_q.ip_addr, iface: req_q.iface_id, sent: now_q,
                      retries: 8'd0, packets: 8'd1};
          pvalid_d[fslot_q] = 1'b1;
          nxt_d = '{kind: arpc_pkg::KindSend, hit: 1'b0, out_ip: req_q.ip_addr,
                    out_mac: 48'd0, out_iface: req_q.iface_id, packet_count: 8'd0,
                    last: 1'b0};
          ret_d = arpc_pkg::StPendAct;
          pi_d  = (PW+1)'(arpc_pkg::PendEntries - 1);
          req_d.mode = arpc_pkg::ModeLookup;
        end else begin
          nxt_d = '{kind: arpc_pkg::KindFull, hit: 1'b0, out_ip: req_q.ip_addr,
                    out_mac: 48'd0, out_iface: req_q.iface_id, packet_count: 8'd0,
                    last: 1'b0};
          ret_d = arpc_pkg::StPendAct;
          pi_d  = (PW+1)'(arpc_pkg::PendEntries - 1);
          req_d.mode = arpc_pkg::ModeLookup;
        end
      end
      arpc_pkg::StOut: begin
        if (out_free) begin
          rsp_d       = nxt_q;
          rsp_valid_d = 1'b1;
          state_d     = ret_q;
        end
      end
      default: state_d = arpc_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  arpc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  arpc_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  arp_cache_with_request_tracking_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_stall_o(req_stall), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_stall_i(rsp_stall), .rsp_o(rsp),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Shadow copy of the cache and pending table, kept in step with every
  // accepted request.
  logic [15:0] timeout_reg;
  logic [7:0]  retries_reg;
  logic [7:0]  resend_reg;
  logic        sh_cvalid [arpc_pkg::CacheEntries];
  logic [31:0] sh_cip    [arpc_pkg::CacheEntries];
  logic [47:0] sh_cmac   [arpc_pkg::CacheEntries];
  logic [15:0] sh_cadded [arpc_pkg::CacheEntries];
  logic        sh_pvalid [arpc_pkg::PendEntries];
  logic [31:0] sh_pip    [arpc_pkg::PendEntries];
  logic [3:0]  sh_piface [arpc_pkg::PendEntries];
  logic [15:0] sh_psent  [arpc_pkg::PendEntries];
  logic [7:0]  sh_pretry [arpc_pkg::PendEntries];
  logic [7:0]  sh_ppkts  [arpc_pkg::PendEntries];
  logic [15:0] sh_now;

  arpc_pkg::rsp_t expected_rsps[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 80;
  logic hold_off = 1'b0;

  // Addresses drawn from a small pool so that hits, releases and repeats
  // are frequent.
  logic [31:0] ip_pool [8];

  function automatic arpc_pkg::rsp_t mk(arpc_pkg::kind_e k, logic h, logic [31:0] ip,
                                        logic [47:0] mac, logic [3:0] ifc,
                                        logic [7:0] cnt, logic lst);
    arpc_pkg::rsp_t r;
    r.kind = k;
    r.hit = h;
    r.out_ip = ip;
    r.out_mac = mac;
    r.out_iface = ifc;
    r.packet_count = cnt;
    r.last = lst;
    return r;
  endfunction

  task automatic reset_shadow();
    timeout_reg = 16'd15;
    retries_reg = 8'd5;
    resend_reg = 8'd1;
    sh_now = '0;
    for (int i = 0; i < arpc_pkg::CacheEntries; i++) begin
      sh_cvalid[i] = 1'b0;
      sh_cip[i] = '0;
      sh_cmac[i] = '0;
      sh_cadded[i] = '0;
    end
    for (int i = 0; i < arpc_pkg::PendEntries; i++) begin
      sh_pvalid[i] = 1'b0;
      sh_pip[i] = '0;
      sh_piface[i] = '0;
      sh_psent[i] = '0;
      sh_pretry[i] = '0;
      sh_ppkts[i] = '0;
    end
  endtask

  // Works out the results of one request and advances the shadow state.
  task automatic predict_arp(arpc_pkg::req_t r);
    int slot;
    int found;
    int freeslot;
    logic [15:0] best;
    logic [15:0] age;
    slot = -1;
    found = -1;
    freeslot = -1;
    best = '0;
    case (arpc_pkg::mode_e'(r.mode))
      arpc_pkg::ModeLookup: begin
        for (int i = 0; i < arpc_pkg::CacheEntries; i++) begin
          if (found < 0 && sh_cvalid[i] && sh_cip[i] == r.ip_addr) found = i;
        end
        if (found >= 0) begin
          expected_rsps.push_back(mk(arpc_pkg::KindLookup, 1'b1, r.ip_addr, sh_cmac[found],
                                     '0, '0, 1'b1));
        end else begin
          expected_rsps.push_back(mk(arpc_pkg::KindLookup, 1'b0, r.ip_addr, '0,
                                     '0, '0, 1'b1));
        end
        return;
      end
      arpc_pkg::ModeInsert: begin
        for (int i = 0; i < arpc_pkg::CacheEntries; i++) begin
          if (slot < 0 && sh_cvalid[i] && sh_cip[i] == r.ip_addr) slot = i;
        end
        if (slot < 0) begin
          for (int i = 0; i < arpc_pkg::CacheEntries; i++) begin
            age = sh_now - sh_cadded[i];
            if (!sh_cvalid[i]) begin
              slot = i;
              break;
            end
            if (slot < 0 || age > best) begin
              slot = i;
              best = age;
            end
          end
        end
        sh_cvalid[slot] = 1'b1;
        sh_cip[slot] = r.ip_addr;
        sh_cmac[slot] = r.mac_addr;
        sh_cadded[slot] = sh_now;
        for (int i = 0; i < arpc_pkg::PendEntries; i++) begin
          if (sh_pvalid[i] && sh_pip[i] == r.ip_addr) begin
            expected_rsps.push_back(mk(arpc_pkg::KindRelease, 1'b0, r.ip_addr, r.mac_addr,
                                       sh_piface[i], sh_ppkts[i], 1'b0));
            sh_pvalid[i] = 1'b0;
          end
        end
      end
      arpc_pkg::ModeAppend: begin
        for (int i = 0; i < arpc_pkg::PendEntries; i++) begin
          if (sh_pvalid[i]) begin
            if (found < 0 && sh_pip[i] == r.ip_addr && sh_piface[i] == r.iface_id) begin
              found = i;
            end
          end else if (freeslot < 0) begin
            freeslot = i;
          end
        end
        if (found >= 0) begin
          if (sh_ppkts[found] != 8'hFF) sh_ppkts[found] = sh_ppkts[found] + 1'b1;
        end else if (freeslot >= 0) begin
          sh_pvalid[freeslot] = 1'b1;
          sh_pip[freeslot] = r.ip_addr;
          sh_piface[freeslot] = r.iface_id;
          sh_psent[freeslot] = sh_now;
          sh_pretry[freeslot] = '0;
          sh_ppkts[freeslot] = 8'd1;
          expected_rsps.push_back(mk(arpc_pkg::KindSend, 1'b0, r.ip_addr, '0, r.iface_id,
                                     '0, 1'b0));
        end else begin
          expected_rsps.push_back(mk(arpc_pkg::KindFull, 1'b0, r.ip_addr, '0, r.iface_id,
                                     '0, 1'b0));
        end
      end
      default: begin
        sh_now = sh_now + 16'd1;
        for (int i = 0; i < arpc_pkg::CacheEntries; i++) begin
          if (sh_cvalid[i] && 16'(sh_now - sh_cadded[i]) > timeout_reg) sh_cvalid[i] = 1'b0;
        end
        for (int i = 0; i < arpc_pkg::PendEntries; i++) begin
          if (!sh_pvalid[i]) continue;
          if (sh_pretry[i] > retries_reg) begin
            expected_rsps.push_back(mk(arpc_pkg::KindUnreach, 1'b0, sh_pip[i], '0,
                                       sh_piface[i], sh_ppkts[i], 1'b0));
            sh_pvalid[i] = 1'b0;
          end else if (16'(sh_now - sh_psent[i]) > 16'(resend_reg)) begin
            expected_rsps.push_back(mk(arpc_pkg::KindSend, 1'b0, sh_pip[i], '0,
                                       sh_piface[i], '0, 1'b0));
            if (sh_pretry[i] != 8'hFF) sh_pretry[i] = sh_pretry[i] + 1'b1;
            sh_psent[i] = sh_now;
          end
        end
      end
    endcase
    expected_rsps.push_back(mk(arpc_pkg::KindDone, 1'b0, '0, '0, '0, '0, 1'b1));
  endtask

  // Sends one request, holding it until the unit accepts it. A random gap
  // comes first so that idle cycles fall on every phase of the sweep.
  task automatic send_request(arpc_pkg::req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_arp(r);
  endtask

  // Waits until every expected result has come back, then lets the unit
  // finish any trailing work before a configuration write.
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(arpc_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      arpc_pkg::CfgTimeout: timeout_reg = val;
      arpc_pkg::CfgRetries: retries_reg = val[7:0];
      default:              resend_reg = val[7:0];
    endcase
  endtask

  function automatic arpc_pkg::req_t mkreq(arpc_pkg::mode_e m, logic [31:0] ip,
                                           logic [47:0] mac, logic [3:0] ifc);
    arpc_pkg::req_t r;
    r.mode = m;
    r.ip_addr = ip;
    r.mac_addr = mac;
    r.iface_id = ifc;
    return r;
  endfunction

  // Random request, weighted toward appends and inserts on a small set of
  // addresses, with ticks often enough to age entries and trigger resends.
  function automatic arpc_pkg::req_t random_req();
    int sel;
    logic [31:0] ip;
    logic [47:0] mac;
    sel = $urandom_range(99, 0);
    ip = ($urandom_range(9, 0) == 0) ? $urandom() : ip_pool[$urandom_range(7, 0)];
    mac = 48'({$urandom(), $urandom()});
    if (sel < 20) return mkreq(arpc_pkg::ModeLookup, ip, mac, 4'($urandom()));
    if (sel < 45) return mkreq(arpc_pkg::ModeInsert, ip, mac, 4'($urandom()));
    if (sel < 75) return mkreq(arpc_pkg::ModeAppend, ip, mac,
                               4'($urandom_range(3, 0) == 0 ? $urandom()
                                                            : $urandom_range(1, 0)));
    return mkreq(arpc_pkg::ModeTick, $urandom(), mac, 4'($urandom()));
  endfunction

  // Directed table. Rows with check set carry their leading result inline;
  // the predictor must agree with them, and the unit is checked against it.
  typedef struct {
    arpc_pkg::req_t r;
    logic check;
    arpc_pkg::rsp_t first;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic build_rows();
    dir_row_t d;
    d.check = 1'b1;
    // Lookups right after reset miss, at both extremes of the address.
    d.r = mkreq(arpc_pkg::ModeLookup, 32'h0, '1, 4'hF);
    d.first = mk(arpc_pkg::KindLookup, 1'b0, 32'h0, '0, '0, '0, 1'b1);
    dir_rows.push_back(d);
    d.r = mkreq(arpc_pkg::ModeLookup, 32'hFFFF_FFFF, '0, 4'h0);
    d.first = mk(arpc_pkg::KindLookup, 1'b0, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
    dir_rows.push_back(d);
    // Opening a request emits a send request.
    d.r = mkreq(arpc_pkg::ModeAppend, 32'hFFFF_FFFF, '0, 4'hF);
    d.first = mk(arpc_pkg::KindSend, 1'b0, 32'hFFFF_FFFF, '0, 4'hF, '0, 1'b0);
    dir_rows.push_back(d);
    d.check = 1'b0;
    d.r = mkreq(arpc_pkg::ModeAppend, 32'hFFFF_FFFF, '0, 4'hF);
    dir_rows.push_back(d);
    d.r = mkreq(arpc_pkg::ModeAppend, 32'hFFFF_FFFF, '0, 4'h0);
    dir_rows.push_back(d);
    // Insert releases both interfaces for the address.
    d.r = mkreq(arpc_pkg::ModeInsert, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'h0);
    dir_rows.push_back(d);
    d.check = 1'b1;
    d.r = mkreq(arpc_pkg::ModeLookup, 32'hFFFF_FFFF, '0, 4'h0);
    d.first = mk(arpc_pkg::KindLookup, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                 '0, '0, 1'b1);
    dir_rows.push_back(d);
    d.check = 1'b0;
    d.r = mkreq(arpc_pkg::ModeInsert, 32'h0, 48'h0, 4'hF);
    dir_rows.push_back(d);
    // Fill the pending table, then overflow it.
    for (int i = 0; i < arpc_pkg::PendEntries; i++) begin
      d.r = mkreq(arpc_pkg::ModeAppend, 32'h0A00_0000 + i, '0, 4'(i));
      dir_rows.push_back(d);
    end
    d.check = 1'b1;
    d.r = mkreq(arpc_pkg::ModeAppend, 32'h0B00_0000, '0, 4'h5);
    d.first = mk(arpc_pkg::KindFull, 1'b0, 32'h0B00_0000, '0, 4'h5, '0, 1'b0);
    dir_rows.push_back(d);
    // Ticks drive resends.
    d.check = 1'b0;
    for (int i = 0; i < 10; i++) begin
      d.r = mkreq(arpc_pkg::ModeTick, '0, '0, '0);
      dir_rows.push_back(d);
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_request(random_req());
    drain();
  endtask

  // Receiver: random stall, or a long hold-off when asked for.
  always @(posedge clk) begin
    rsp_stall <= hold_off || ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    arpc_pkg::rsp_t exp_r;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", exp_r, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    arpc_pkg::rsp_t lead;
    reset_shadow();
    for (int i = 0; i < 8; i++) ip_pool[i] = (i == 0) ? 32'h0 : $urandom();
    build_rows();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].r);
      if (dir_rows[i].check) begin
        // The row's results were just queued at the tail.
        if (dir_rows[i].r.mode == arpc_pkg::ModeLookup) begin
          lead = expected_rsps[expected_rsps.size() - 1];
        end else begin
          lead = expected_rsps[expected_rsps.size() - 2];
        end
        if (lead !== dir_rows[i].first) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %p, predicted %p", i, dir_rows[i].first, lead);
        end
      end
    end
    drain();

    // Long receiver hold-off while the sender keeps offering requests.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_request(mkreq(arpc_pkg::ModeTick, '0, '0, '0));
      end
      begin
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    write_cfg(arpc_pkg::CfgTimeout, 16'd1);
    write_cfg(arpc_pkg::CfgRetries, 16'd0);
    write_cfg(arpc_pkg::CfgResend, 16'd0);
    random_phase(170);

    send_idle_pct = 80;
    recv_idle_pct = 32;
    write_cfg(arpc_pkg::CfgTimeout, 16'hFFFF);
    write_cfg(arpc_pkg::CfgRetries, 16'hFF);
    write_cfg(arpc_pkg::CfgResend, 16'hFF);
    random_phase(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(arpc_pkg::CfgTimeout, 16'd4);
    write_cfg(arpc_pkg::CfgRetries, 16'd2);
    write_cfg(arpc_pkg::CfgResend, 16'd1);
    random_phase(170);

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_cache_with_request_tracking_unit.sv
bench/tb.sv
